// ===== rtl/core/ssbc_pkg.sv =====
// Package for the semaphore set blocker check: sizes, codes, payload structs
// and the queue item passed from the front part to the back part.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ssbc_pkg;

   // Capacity of the semaphore set and of one operation set.
   localparam int MAX_SEMS = 1024;
   localparam int MAX_OPS = 256;

   // Derived widths.
   localparam int IDX_W = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
   localparam int POS_W = $clog2(MAX_OPS + 2);

   // Fixed field widths.
   localparam int CFG_W = 11;
   localparam int FIELD_W = 16;
   localparam int WORK_W = 24;
   localparam int BLK_W = 8;
   localparam int EPOCH_W = 8;

   // Saturation limit of a working value.
   localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

   // Epoch marks: zero means untouched, the last code forces a clearing pass.
   localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};

   // Queue between the front and the back part.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_OP   = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      VERDICT_PROCEED  = 3'd0,
      VERDICT_WAIT     = 3'd1,
      VERDICT_REFUSE   = 3'd2,
      VERDICT_UNKNOWN  = 3'd3,
      VERDICT_BADCOUNT = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_ZERO = 2'd1,
      OP_TAKE = 2'd2
   } op_class_type;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'd0,
      BK_IDLE  = 2'd1,
      BK_EXEC  = 2'd2
   } back_state_type;

   // Input item as it arrives on the command port.
   typedef struct packed {
      logic                       command;
      logic [FIELD_W-1:0]         sem_index;
      logic [FIELD_W-1:0]         load_value;
      logic signed [FIELD_W-1:0]  op_amount;
      logic                       no_wait;
      logic                       last_op;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [2:0]       verdict;
      logic [BLK_W-1:0] blocker_position;
   } rsp_type;

   // Classified item held in the queue.
   typedef struct packed {
      logic               is_load;
      logic               load_ok;
      logic [IDX_W-1:0]   index;
      logic [FIELD_W-1:0] load_value;
      op_class_type       op_class;
      logic [FIELD_W-1:0] amount;
      logic               no_wait;
      logic               last;
      logic               evaluate;
      logic               unknown;
      logic               bad_count;
      logic [POS_W-1:0]   position;
   } qitem_type;

   // Queue fill status.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Status of the back part seen by the top level.
   typedef struct packed {
      logic clearing;
      logic popping;
   } back_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/ssbc_front.sv =====
// Front part of the semaphore set blocker check: holds the set size register,
// counts op positions and classifies each accepted item for the back part.
// Depends on ssbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssbc_front import ssbc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire req_type          req_data,
   input  wire logic             csr_we,
   input  wire logic [CFG_W-1:0] csr_wdata,
   output logic                  push,
   output qitem_type             push_item
);

   logic [CFG_W-1:0] set_size_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pos_next;
   logic             is_op;
   logic [FIELD_W:0] index_wide;
   logic [FIELD_W:0] size_wide;

   // Set size register; the user must write it only while the block is idle, the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= '0;
      end else if (csr_we) begin
         set_size_ff <= csr_wdata;
      end
   end

   assign is_op = (req_data.command == CMD_OP);
   assign index_wide = {1'b0, req_data.sem_index};
   assign size_wide = (FIELD_W + 1)'(set_size_ff);

   // The op count saturates one past the limit.
   always_comb begin
      pos_next = pos_ff;
      if (pos_ff <= POS_W'(MAX_OPS)) begin
         pos_next = pos_ff + POS_W'(1);
      end
      pos_in = pos_ff;
      if (accept && is_op) begin
         pos_in = req_data.last_op ? '0 : pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Classification of the item.
   always_comb begin
      push_item.is_load = !is_op;
      push_item.load_ok = (index_wide < (FIELD_W + 1)'(MAX_SEMS));
      push_item.index = req_data.sem_index[IDX_W-1:0];
      push_item.load_value = req_data.load_value;
      push_item.no_wait = req_data.no_wait;
      push_item.last = req_data.last_op;
      push_item.evaluate = (pos_ff < POS_W'(MAX_OPS));
      push_item.unknown = (set_size_ff == '0) || (size_wide > (FIELD_W + 1)'(MAX_SEMS))
                          || (index_wide >= size_wide);
      push_item.bad_count = (pos_next > POS_W'(MAX_OPS));
      push_item.position = pos_ff;
      if (req_data.op_amount == '0) begin
         push_item.op_class = OP_ZERO;
         push_item.amount = '0;
      end else if (!req_data.op_amount[FIELD_W-1]) begin
         push_item.op_class = OP_ADD;
         push_item.amount = req_data.op_amount;
      end else begin
         // Magnitude of a negative op; the most negative value still fits.
         push_item.op_class = OP_TAKE;
         push_item.amount = FIELD_W'(0) - FIELD_W'(req_data.op_amount);
      end
   end

   assign push = accept;

endmodule

`default_nettype wire

// ===== rtl/core/ssbc_queue.sv =====
// Short queue of classified items between the front and the back part.
// Depends on ssbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssbc_queue import ssbc_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire qitem_type push_item,
   input  wire logic      pop,
   output qitem_type      head,
   output q_status_type   status
);

   qitem_type         entries_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   function automatic logic [QPTR_W-1:0] ptr_step(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] nxt;
      nxt = (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
      return nxt;
   endfunction

   // Storage; written on every push.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_step(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_step(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   assign head = entries_ff[rd_ptr_ff];
   assign status.full = (count_ff == QCNT_W'(QDEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/ssbc_back.sv =====
// Back part of the semaphore set blocker check: owns the loaded and working
// value memories, applies each op and delivers the verdict of a set.
// Depends on ssbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssbc_back import ssbc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire qitem_type    head,
   input  wire q_status_type q_status,
   output back_status_type   status,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam int TAGGED_W = EPOCH_W + WORK_W;

   // Memories: loaded values, and working values tagged with a set epoch.
   logic [FIELD_W-1:0]  loaded_mem [MAX_SEMS];
   logic [TAGGED_W-1:0] work_mem [MAX_SEMS];

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [IDX_W-1:0]    clr_ff;
   logic [EPOCH_W-1:0]  epoch_ff;
   qitem_type           item_ff;
   logic [FIELD_W-1:0]  rd_loaded_ff;
   logic [TAGGED_W-1:0] rd_work_ff;
   verdict_type         verdict_ff;
   verdict_type         verdict_in;
   logic [BLK_W-1:0]    blocker_ff;
   logic [BLK_W-1:0]    blocker_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                pop;
   logic                clearing;
   logic                exec;
   logic                clr_done;
   logic                set_end;
   logic [WORK_W-1:0]   cur;
   logic [WORK_W:0]     sum;
   logic                blocked;
   logic                work_we;
   logic [WORK_W-1:0]   work_val;
   logic                report;
   rsp_type             report_data;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_done) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (!q_status.empty) state_in = BK_EXEC;
         end
         BK_EXEC: begin
            state_in = (set_end && epoch_ff == EPOCH_LAST) ? BK_CLEAR : BK_IDLE;
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      pop = 1'b0;
      clearing = 1'b0;
      exec = 1'b0;
      case (state_ff)
         BK_CLEAR: clearing = 1'b1;
         BK_IDLE:  pop = !q_status.empty;
         BK_EXEC:  exec = 1'b1;
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   assign clr_done = (clr_ff == IDX_W'(MAX_SEMS - 1));
   assign set_end = exec && !item_ff.is_load && item_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff <= '0;
         epoch_ff <= EPOCH_FIRST;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_ff <= clr_done ? '0 : clr_ff + IDX_W'(1);
         end
         if (set_end) begin
            epoch_ff <= (epoch_ff == EPOCH_LAST) ? EPOCH_FIRST : epoch_ff + EPOCH_W'(1);
         end
      end
   end

   // Item and memory reads, taken when the item leaves the queue.
   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head;
         rd_loaded_ff <= loaded_mem[head.index];
         rd_work_ff <= work_mem[head.index];
      end
   end

   // Current value: the working copy if touched in this set, else the loaded value.
   assign cur = (rd_work_ff[TAGGED_W-1:WORK_W] == epoch_ff) ? rd_work_ff[WORK_W-1:0]
                                                             : WORK_W'(rd_loaded_ff);
   assign sum = {1'b0, cur} + (WORK_W + 1)'(item_ff.amount);

   // Op evaluation and verdict update.
   always_comb begin
      verdict_in = verdict_ff;
      blocker_in = blocker_ff;
      work_we = 1'b0;
      work_val = cur;
      blocked = 1'b0;
      if (exec && !item_ff.is_load && item_ff.evaluate && verdict_ff == VERDICT_PROCEED) begin
         if (item_ff.unknown) begin
            verdict_in = VERDICT_UNKNOWN;
            blocker_in = '0;
         end else begin
            work_we = 1'b1;
            case (item_ff.op_class)
               OP_ADD: begin
                  work_val = sum[WORK_W] ? WORK_MAX : sum[WORK_W-1:0];
               end
               OP_ZERO: begin
                  blocked = (cur != '0);
               end
               OP_TAKE: begin
                  if (cur >= WORK_W'(item_ff.amount)) begin
                     work_val = cur - WORK_W'(item_ff.amount);
                  end else begin
                     blocked = 1'b1;
                  end
               end
               default: begin
                  blocked = 1'b0;
               end
            endcase
            if (blocked) begin
               verdict_in = item_ff.no_wait ? VERDICT_REFUSE : VERDICT_WAIT;
               blocker_in = BLK_W'(item_ff.position);
            end
         end
      end
   end

   // Result of a set, formed on its last op.
   always_comb begin
      report = set_end;
      if (item_ff.bad_count) begin
         report_data.verdict = VERDICT_BADCOUNT;
         report_data.blocker_position = '0;
      end else begin
         report_data.verdict = verdict_in;
         report_data.blocker_position =
            (verdict_in == VERDICT_WAIT || verdict_in == VERDICT_REFUSE) ? blocker_in : '0;
      end
   end

   // Held verdict, cleared at the end of each set.
   always_ff @(posedge clock) begin
      if (reset) begin
         verdict_ff <= VERDICT_PROCEED;
         blocker_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= report;
         if (set_end) begin
            verdict_ff <= VERDICT_PROCEED;
            blocker_ff <= '0;
         end else begin
            verdict_ff <= verdict_in;
            blocker_ff <= blocker_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (report) begin
         rsp_data_ff <= report_data;
      end
   end

   // Memory writes: loads, working values and the clearing pass.
   always_ff @(posedge clock) begin
      if (exec && item_ff.is_load && item_ff.load_ok) begin
         loaded_mem[item_ff.index] <= item_ff.load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         work_mem[clr_ff] <= {EPOCH_NONE, {WORK_W{1'b0}}};
      end else if (work_we) begin
         work_mem[item_ff.index] <= {epoch_ff, work_val};
      end
   end

   assign status.clearing = clearing;
   assign status.popping = pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // An item leaves the queue only when one is there.
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("ssbc_back: pop from an empty queue");

   // Execution always follows the cycle that took the item from the queue.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EXEC) |-> $past(pop))
      else $error("ssbc_back: execution without a popped item");

   // A result appears only after the last op of a set was executed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(exec) && !$past(item_ff.is_load) && $past(item_ff.last))
      else $error("ssbc_back: result without a last op");

   // Only wait and refuse carry a blocker position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict != VERDICT_WAIT && rsp_data.verdict != VERDICT_REFUSE
      |-> rsp_data.blocker_position == '0)
      else $error("ssbc_back: blocker position on a non-blocking verdict");

   // Working entries are never written while the clearing pass runs.
   assert property (@(posedge clock) disable iff (reset) clearing |-> !work_we && !pop)
      else $error("ssbc_back: item handled during the clearing pass");

endmodule

`default_nettype wire

// ===== rtl/core/semaphore_set_blocker_check.sv =====
// Top level of the semaphore set blocker check: front part, item queue and
// back part. Depends on ssbc_pkg, ssbc_front, ssbc_queue and ssbc_back.
//
//   Channel   Ports                   Handshake
//   input     start, busy, req_data   taken at an edge with start high, busy low
//   result    rsp_valid, rsp_data     one-cycle strobe, no back-pressure
//   config    csr_we, csr_wdata       written at an edge with csr_we high
//
// The back part handles each item in two states: IDLE takes it from the queue
// and reads both value memories, EXEC applies it and writes back. The result
// of a set is registered from the EXEC state of its last op. A new item is
// taken only once the last one is through; busy rises when the queue is full.
// After reset, and after every 255th set, a clearing pass over all MAX_SEMS
// (1024) entries resets the working-value epoch marks; busy is high throughout.
// Results cannot be stalled: the receiver takes each one in its strobe cycle.
`timescale 1ns / 1ps
`default_nettype none

module semaphore_set_blocker_check import ssbc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire logic             csr_we,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   logic            accept;
   logic            push;
   qitem_type       push_item;
   qitem_type       head;
   q_status_type    q_status;
   back_status_type back_status;

   // New items are held off while the queue is full or memories are cleared.
   assign busy = q_status.full || back_status.clearing;
   assign accept = start && !busy;

   ssbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .push_item (push_item)
   );

   ssbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (back_status.popping),
      .head      (head),
      .status    (q_status)
   );

   ssbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .status    (back_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
